/* sv/sbh_pkg.sv */
package sbh_pkg;

    localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] HASH_MUL_LO = HASH_MUL[31:0];
    localparam logic [31:0] HASH_MUL_HI = HASH_MUL[63:32];
    localparam int          MIX_SHIFT  = 47;
    localparam logic [5:0]  BLOCK_BYTES = 6'd32;

    localparam int WORD_W   = 64;
    localparam int LEN_W    = 32;
    localparam int WCOUNT_W = 30;
    localparam int BLOCKS_W = 28;

    typedef struct packed {
        logic [WORD_W-1:0] word_data;
        logic [WORD_W-1:0] init_hash;
        logic              start;
        logic              last;
    } sbh_entry_t;

endpackage

/* sv/sbh_front.sv */
module sbh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [95:0]        s_tdata,    // data_word[63:0], total_length[95:64]
    input  logic               s_tuser,    // is_first
    output logic               push_valid,
    input  logic               push_ready,
    output sbh_pkg::sbh_entry_t push_data
);
    import sbh_pkg::*;

    typedef enum logic [1:0] {
        F_TAKE,
        F_LM0,
        F_LM1,
        F_PUSH
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [WCOUNT_W-1:0]   wc_reg, wc_next;
    logic [WORD_W-1:0]     prod_reg, prod_next;
    logic [WORD_W-1:0]     init_reg, init_next;

    logic [LEN_W:0]        len_round;
    logic [BLOCKS_W-1:0]   blocks_raw;
    logic [BLOCKS_W-1:0]   blocks;
    logic [BLOCKS_W-1:0]   blocks_m1;
    logic [WCOUNT_W-1:0]   total_words;
    logic [WCOUNT_W-1:0]   wc_inc;
    logic                  last_word;
    logic                  last_block;
    logic [LEN_W-1:0]      tail_bytes;
    logic [5:0]            fill_n;
    logic [WORD_W-1:0]     prep_word;
    logic [31:0]           lm_hi;

    assign len_round   = {1'b0, len_reg} + 33'd31;
    assign blocks_raw  = len_round[LEN_W:5];
    assign blocks      = (blocks_raw == '0) ? BLOCKS_W'(1) : blocks_raw;
    assign blocks_m1   = blocks - BLOCKS_W'(1);
    assign total_words = {blocks, 2'b00};
    assign wc_inc      = wc_reg + WCOUNT_W'(1);
    assign last_word   = (wc_inc == total_words);
    assign last_block  = (wc_reg[WCOUNT_W-1:2] == blocks_m1);
    assign tail_bytes  = len_reg - {blocks_m1[26:0], 5'b00000};
    assign fill_n      = last_block ? tail_bytes[5:0] : BLOCK_BYTES;
    assign lm_hi       = len_reg * HASH_MUL_HI;

    always_comb
    begin
        logic [5:0] idx;
        logic [7:0] byte_val;
        prep_word = '0;
        for (int k = 0; k < 8; k++)
        begin
            idx      = {1'b0, wc_reg[1:0], 3'(k)};
            byte_val = (idx >= fill_n) ? 8'h00 : word_reg[8*k +: 8];
            prep_word[8*k +: 8] = byte_val + {2'b00, fill_n};
        end
    end

    assign s_tready   = (state_reg == F_TAKE);
    assign push_valid = (state_reg == F_PUSH);

    always_comb
    begin
        push_data.word_data = prep_word;
        push_data.init_hash = init_reg;
        push_data.start     = (wc_reg == '0);
        push_data.last      = last_word;
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        len_next   = len_reg;
        wc_next    = wc_reg;
        prod_next  = prod_reg;
        init_next  = init_reg;
        case (state_reg)
            F_TAKE:
            begin
                if (s_tvalid)
                begin
                    word_next = s_tdata[63:0];
                    if (s_tuser)
                    begin
                        len_next   = s_tdata[95:64];
                        wc_next    = '0;
                        state_next = F_LM0;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_LM0:
            begin
                prod_next  = {32'h0, len_reg} * {32'h0, HASH_MUL_LO};
                state_next = F_LM1;
            end
            F_LM1:
            begin
                init_next  = prod_reg + {lm_hi, 32'h0};
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    wc_next    = last_word ? '0 : wc_inc;
                    state_next = F_TAKE;
                end
            end
            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_TAKE;
            word_reg  <= '0;
            len_reg   <= '0;
            wc_reg    <= '0;
            prod_reg  <= '0;
            init_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            len_reg   <= len_next;
            wc_reg    <= wc_next;
            prod_reg  <= prod_next;
            init_reg  <= init_next;
        end
    end

endmodule

/* sv/sbh_queue.sv */
module sbh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sbh_pkg::sbh_entry_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sbh_pkg::sbh_entry_t pop_data
);
    import sbh_pkg::*;

    sbh_entry_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/sbh_back.sv */
module sbh_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  sbh_pkg::sbh_entry_t pop_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata    // hash_value
);
    import sbh_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2
    } back_state_t;

    function automatic logic [63:0] shift_mix(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

    back_state_t        state_reg, state_next;
    logic [WORD_W-1:0]  hash_reg, hash_next;
    logic [WORD_W-1:0]  opa_reg, opa_next;
    logic [WORD_W-1:0]  p0_reg, p0_next;
    logic [31:0]        c1_reg, c1_next;
    logic               fin_reg, fin_next;
    logic               last_reg, last_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_data_reg, out_data_next;

    logic [WORD_W-1:0]  opa_in;
    logic [WORD_W-1:0]  base_hash;
    logic [31:0]        c2;
    logic [31:0]        cross_sum;
    logic [WORD_W-1:0]  product;
    logic [WORD_W-1:0]  mixed;
    logic               out_free;

    assign pop_ready = (state_reg == B_IDLE) && !pend_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign base_hash = pop_data.start ? pop_data.init_hash : hash_reg;
    assign opa_in    = pend_reg ? shift_mix(hash_reg) : (base_hash ^ pop_data.word_data);
    assign c2        = opa_reg[31:0] * HASH_MUL_HI;
    assign cross_sum = c1_reg + c2;
    assign product   = p0_reg + {cross_sum, 32'h0};
    assign mixed     = shift_mix(product);

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        opa_next       = opa_reg;
        p0_next        = p0_reg;
        c1_next        = c1_reg;
        fin_next       = fin_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pend_reg || pop_valid)
                begin
                    opa_next   = opa_in;
                    p0_next    = {32'h0, opa_in[31:0]} * {32'h0, HASH_MUL_LO};
                    fin_next   = pend_reg;
                    last_next  = pend_reg ? 1'b0 : pop_data.last;
                    pend_next  = 1'b0;
                    state_next = B_MUL1;
                end
            end
            B_MUL1:
            begin
                c1_next    = opa_reg[63:32] * HASH_MUL_LO;
                state_next = B_MUL2;
            end
            B_MUL2:
            begin
                if (fin_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = mixed;
                        state_next     = B_IDLE;
                    end
                end
                else
                begin
                    hash_next  = mixed;
                    pend_next  = last_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            hash_reg      <= '0;
            opa_reg       <= '0;
            p0_reg        <= '0;
            c1_reg        <= '0;
            fin_reg       <= 1'b0;
            last_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            opa_reg       <= opa_next;
            p0_reg        <= p0_next;
            c1_reg        <= c1_next;
            fin_reg       <= fin_next;
            last_reg      <= last_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

/* sv/string_block_hash_core.sv */
// Streaming 64-bit string hash (murmur64a style, 32-byte blocks). Send the string as
// little-endian words, four per block, is_first set on the first word along with the
// length; the hash comes out one transfer after the last word. The back end runs each word
// through B_IDLE, B_MUL1 and B_MUL2, building the 64x64 low product from three 32x32
// partial products, one per state; a string's last word adds a finalization pass. A word
// with is_first set passes F_LM0 and F_LM1 in the front end to form length*M, hidden
// behind a two-entry queue. No clearing pass after reset.
module string_block_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // data_word[63:0], total_length[95:64]
    input  logic        s_tuser,    // is_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // hash_value
);
    import sbh_pkg::*;

    logic       q_push_valid;
    logic       q_push_ready;
    sbh_entry_t q_push_data;
    logic       q_pop_valid;
    logic       q_pop_ready;
    sbh_entry_t q_pop_data;

    sbh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    sbh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    sbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_front_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front accepted back-to-back transfers");

    a_push_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push_valid && q_push_ready) |=> !(q_push_valid && q_push_ready))
        else $error("queue pushed in consecutive cycles");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop_valid && q_pop_ready) |=> !(q_pop_valid && q_pop_ready))
        else $error("back end popped while multiply in flight");

endmodule
